### src/fbdt_pkg.sv
// shared types, constants and action codes of the framebuffer dirty tracker
`default_nettype none

package fbdt_pkg;

	localparam int FRAME_WIDTH_DEF  = 400;
	localparam int FRAME_HEIGHT_DEF = 300;
	localparam int LINE_BYTES_DEF   = 50;

	localparam logic [2:0] ACT_WRITE = 3'd0;
	localparam logic [2:0] ACT_TAKE  = 3'd1;
	localparam logic [2:0] ACT_FULL  = 3'd2;
	localparam logic [2:0] ACT_MARK  = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	localparam logic [7:0] PIXEL_MSB = 8'h80;

	typedef struct packed {
		logic [2:0] action;
		logic [8:0] pixel_x;
		logic [8:0] pixel_y;
		logic       ink_black;
	} fbdt_cmd_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] read_byte;
		logic [8:0] area_x;
		logic [8:0] area_y;
		logic [8:0] area_width;
		logic [8:0] area_height;
		logic       baseline_ok;
	} fbdt_res_t;

	typedef struct packed {
		logic [8:0] left;
		logic [8:0] top;
		logic [8:0] wide;
		logic [8:0] tall;
	} fbdt_rect_t;

	typedef struct packed {
		logic       commit;
		logic [2:0] action;
		logic [8:0] pixel_x;
		logic [8:0] pixel_y;
		logic       in_frame;
	} fbdt_step_t;

endpackage

`default_nettype wire

### src/fbdt_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module fbdt_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### src/fbdt_area.sv
// dirty rectangle and baseline flag registers with merge logic
`default_nettype none

module fbdt_area #(
	parameter int FRAME_WIDTH  = fbdt_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = fbdt_pkg::FRAME_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fbdt_pkg::fbdt_step_t step,
	output fbdt_pkg::fbdt_rect_t      report,
	output logic                      baseline_ok
);

	import fbdt_pkg::*;

	fbdt_rect_t rect_q;
	logic       base_q;
	fbdt_rect_t full_rect;
	fbdt_rect_t merged;
	fbdt_rect_t point_rect;
	fbdt_rect_t rect_next;
	logic       base_next;
	logic [9:0] right_old;
	logic [9:0] bottom_old;
	logic [9:0] right_pt;
	logic [9:0] bottom_pt;
	logic [9:0] right_new;
	logic [9:0] bottom_new;
	logic [8:0] left_new;
	logic [8:0] top_new;

	assign full_rect = '{left: '0, top: '0, wide: 9'(FRAME_WIDTH), tall: 9'(FRAME_HEIGHT)};

	always_comb begin
		right_old  = 10'(rect_q.left) + 10'(rect_q.wide);
		bottom_old = 10'(rect_q.top) + 10'(rect_q.tall);
		right_pt   = 10'(step.pixel_x) + 10'd1;
		bottom_pt  = 10'(step.pixel_y) + 10'd1;
		right_new  = (right_pt > right_old) ? right_pt : right_old;
		bottom_new = (bottom_pt > bottom_old) ? bottom_pt : bottom_old;
		left_new   = (step.pixel_x < rect_q.left) ? step.pixel_x : rect_q.left;
		top_new    = (step.pixel_y < rect_q.top) ? step.pixel_y : rect_q.top;
		point_rect = '{left: step.pixel_x, top: step.pixel_y, wide: 9'd1, tall: 9'd1};

		if (rect_q.wide == '0 || rect_q.tall == '0) begin
			merged = point_rect;
		end else begin
			merged.left = left_new;
			merged.top  = top_new;
			merged.wide = 9'(right_new - 10'(left_new));
			merged.tall = 9'(bottom_new - 10'(top_new));
		end
		// without a valid baseline the whole panel has to go out
		if (!base_q) begin
			merged = full_rect;
		end
	end

	always_comb begin
		rect_next = rect_q;
		base_next = base_q;
		unique case (step.action)
			ACT_WRITE: begin
				if (step.in_frame) begin
					rect_next = merged;
				end
			end
			ACT_TAKE: begin
				rect_next = '0;
			end
			ACT_FULL: begin
				rect_next = full_rect;
				base_next = 1'b0;
			end
			ACT_MARK: begin
				base_next = 1'b1;
			end
			default: begin
				rect_next = rect_q;
			end
		endcase
	end

	// take reports the rectangle as it stood before the clear
	assign report      = (step.action == ACT_TAKE) ? rect_q : rect_next;
	assign baseline_ok = base_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q <= '0;
			base_q <= 1'b0;
		end else if (step.commit) begin
			rect_q <= rect_next;
			base_q <= base_next;
		end
	end

endmodule

`default_nettype wire

### src/pixel_framebuffer_dirty_tracker_top.sv
// top level of the one-bit framebuffer with dirty rectangle tracking
//
//  channel | signals                      | direction | payload
//  --------+------------------------------+-----------+---------------------------
//  command | cmd_valid, cmd_ready, cmd    | in        | action, x, y, ink
//  result  | res_valid, res_ready, res    | out       | accepted, byte, area, flag
//
// every command first reads the frame byte from the store, then modifies it,
// writes it back and loads the result register
// a new command is taken once the previous one has written back, so read and
// write never meet on one byte and no forwarding is needed
// after reset the store is swept to zero, all LINE_BYTES*FRAME_HEIGHT bytes (15000 by default),
// with cmd_ready low; a result waiting on res_ready holds the item in its write-back step
`default_nettype none

module pixel_framebuffer_dirty_tracker_top #(
	parameter int FRAME_WIDTH  = fbdt_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = fbdt_pkg::FRAME_HEIGHT_DEF,
	parameter int LINE_BYTES   = fbdt_pkg::LINE_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire fbdt_pkg::fbdt_cmd_t cmd,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output fbdt_pkg::fbdt_res_t      res
);

	import fbdt_pkg::*;

	localparam int STORE_BYTES = LINE_BYTES * FRAME_HEIGHT;
	localparam int RAM_AW      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CALC_W      = 16;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_BUSY  = 2'd2;

	logic [1:0]        state_q;
	logic [RAM_AW-1:0] clr_addr_q;
	logic              clr_last;
	logic              cmd_xfer;
	logic              in_frame;
	logic [CALC_W-1:0] byte_addr;
	logic              addr_ok;

	// item held across the read cycle
	fbdt_cmd_t         cmd_s1;
	logic              in_frame_s1;
	logic              addr_ok_s1;
	logic [RAM_AW-1:0] addr_s1;

	logic              res_valid_q;
	fbdt_res_t         res_q;
	logic              res_free;
	logic              commit;

	logic              ram_wr_en;
	logic [RAM_AW-1:0] ram_wr_addr;
	logic [7:0]        ram_wr_data;
	logic [7:0]        ram_rd_data;
	logic [7:0]        bit_mask;
	logic [7:0]        byte_mod;

	fbdt_step_t        step;
	fbdt_rect_t        area_report;
	logic              area_base;
	logic              res_accepted;

	assign clr_last  = (clr_addr_q == RAM_AW'(STORE_BYTES - 1));
	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;

	// frame bounds and packed byte address, msb is the leftmost pixel
	assign in_frame  = ({1'b0, cmd.pixel_x} < 10'(FRAME_WIDTH)) &&
	                   ({1'b0, cmd.pixel_y} < 10'(FRAME_HEIGHT));
	assign byte_addr = CALC_W'(cmd.pixel_y) * CALC_W'(LINE_BYTES) + CALC_W'(cmd.pixel_x[8:3]);
	assign addr_ok   = (byte_addr < CALC_W'(STORE_BYTES));

	// result register parts the two sides; commit only when it is free
	assign res_free = !res_valid_q || res_ready;
	assign commit   = (state_q == ST_BUSY) && res_free;

	// read-modify-write of one byte
	assign bit_mask = PIXEL_MSB >> cmd_s1.pixel_x[2:0];
	assign byte_mod = cmd_s1.ink_black ? (ram_rd_data | bit_mask) : (ram_rd_data & ~bit_mask);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = '0;
		end else begin
			ram_wr_en   = commit && (cmd_s1.action == ACT_WRITE) && in_frame_s1 && addr_ok_s1;
			ram_wr_addr = addr_s1;
			ram_wr_data = byte_mod;
		end
	end

	fbdt_ram #(
		.WIDTH  (8),
		.DEPTH  (STORE_BYTES),
		.ADDR_W (RAM_AW)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (cmd_xfer && addr_ok),
		.rd_addr (byte_addr[RAM_AW-1:0]),
		.rd_data (ram_rd_data)
	);

	assign step = '{
		commit:   commit,
		action:   cmd_s1.action,
		pixel_x:  cmd_s1.pixel_x,
		pixel_y:  cmd_s1.pixel_y,
		in_frame: in_frame_s1
	};

	fbdt_area #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_area (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.report      (area_report),
		.baseline_ok (area_base)
	);

	always_comb begin
		unique case (cmd_s1.action)
			ACT_WRITE, ACT_READ:          res_accepted = in_frame_s1;
			ACT_TAKE, ACT_FULL, ACT_MARK: res_accepted = 1'b1;
			default:                      res_accepted = 1'b0;
		endcase
	end

	// control: clearing sweep, idle, busy with an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + RAM_AW'(1);
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_xfer) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_s1      <= cmd;
			in_frame_s1 <= in_frame;
			addr_ok_s1  <= addr_ok;
			addr_s1     <= byte_addr[RAM_AW-1:0];
		end
		if (commit) begin
			res_q.accepted    <= res_accepted;
			res_q.read_byte   <= ((cmd_s1.action == ACT_READ) && in_frame_s1 && addr_ok_s1)
			                     ? ram_rd_data : 8'd0;
			res_q.area_x      <= area_report.left;
			res_q.area_y      <= area_report.top;
			res_q.area_width  <= area_report.wide;
			res_q.area_height <= area_report.tall;
			res_q.baseline_ok <= area_base;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### src/fbdt_checker.sv
// port-level checks for the framebuffer dirty tracker, bound to the top level
`default_nettype none

module fbdt_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_ready,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire fbdt_pkg::fbdt_res_t res
);

	import fbdt_pkg::*;

	// one item at a time: no second transfer right after a command
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one in flight");

	// a waiting result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result dropped or changed while stalled");

	// a result goes away only through a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(res_ready))
		else $error("result withdrawn without transfer");

	// a nonzero byte only comes back from an accepted read
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.read_byte != 8'd0) |-> res.accepted)
		else $error("read byte on rejected command");

endmodule

bind pixel_framebuffer_dirty_tracker_top fbdt_checker u_fbdt_checker (.*);

`default_nettype wire

### sim/tb_pixel_framebuffer_dirty_tracker_top.sv
// self-checking testbench for the one-bit framebuffer with dirty rectangle tracking
module tb_pixel_framebuffer_dirty_tracker_top;
	import fbdt_pkg::*;

	localparam int FRAME_W     = FRAME_WIDTH_DEF;
	localparam int FRAME_H     = FRAME_HEIGHT_DEF;
	localparam int STORE_BYTES = LINE_BYTES_DEF * FRAME_HEIGHT_DEF;

	// action codes the block decodes as no-ops
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	// the clearing sweep after reset passes without any transfer, so the limit must cover it
	localparam int STALL_LIMIT  = 60000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int SPOT_DEPTH   = 16;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	fbdt_cmd_t cmd       = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	fbdt_res_t res;

	always #10 clk = ~clk;

	pixel_framebuffer_dirty_tracker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// shadow copy of the frame, the dirty rectangle and the baseline flag
	logic [7:0] shadow_frame [STORE_BYTES];
	fbdt_rect_t dirty_box;
	logic       shadow_base;

	fbdt_res_t  pending_results [$];
	fbdt_cmd_t  written_spots [$];
	int         error_count = 0;
	int         idle_cycles = 0;
	bit         tx_idling;
	bit         rx_idling;
	bit         long_hold_req = 1'b0;
	int         cluster_x;
	int         cluster_y;

	function automatic void mark_full_screen();
		dirty_box.left = '0;
		dirty_box.top  = '0;
		dirty_box.wide = 9'(FRAME_W);
		dirty_box.tall = 9'(FRAME_H);
	endfunction

	// advance the shadow state by one command and return the result it should produce
	function automatic fbdt_res_t apply_command(fbdt_cmd_t c);
		fbdt_res_t  r;
		fbdt_rect_t shown;
		logic       in_frame;
		int         addr;
		int         right;
		int         bottom;
		logic [7:0] bit_mask;
		in_frame = (int'(c.pixel_x) < FRAME_W) && (int'(c.pixel_y) < FRAME_H);
		addr     = int'(c.pixel_y) * LINE_BYTES_DEF + int'(c.pixel_x >> 3);
		bit_mask = PIXEL_MSB >> c.pixel_x[2:0];
		r        = '0;
		shown    = dirty_box;
		case (c.action)
			ACT_WRITE: begin
				if (in_frame) begin
					if (c.ink_black)
						shadow_frame[addr] = shadow_frame[addr] | bit_mask;
					else
						shadow_frame[addr] = shadow_frame[addr] & ~bit_mask;
					if (dirty_box.wide == '0 || dirty_box.tall == '0) begin
						dirty_box.left = c.pixel_x;
						dirty_box.top  = c.pixel_y;
						dirty_box.wide = 9'd1;
						dirty_box.tall = 9'd1;
					end else begin
						right  = int'(dirty_box.left) + int'(dirty_box.wide);
						bottom = int'(dirty_box.top) + int'(dirty_box.tall);
						if (int'(c.pixel_x) + 1 > right)
							right = int'(c.pixel_x) + 1;
						if (int'(c.pixel_y) + 1 > bottom)
							bottom = int'(c.pixel_y) + 1;
						if (c.pixel_x < dirty_box.left)
							dirty_box.left = c.pixel_x;
						if (c.pixel_y < dirty_box.top)
							dirty_box.top = c.pixel_y;
						dirty_box.wide = 9'(right - int'(dirty_box.left));
						dirty_box.tall = 9'(bottom - int'(dirty_box.top));
					end
					// no valid baseline: any change means a full refresh
					if (!shadow_base)
						mark_full_screen();
					r.accepted = 1'b1;
				end
			end
			ACT_TAKE: begin
				dirty_box  = '0;
				r.accepted = 1'b1;
			end
			ACT_FULL: begin
				shadow_base = 1'b0;
				mark_full_screen();
				r.accepted = 1'b1;
			end
			ACT_MARK: begin
				shadow_base = 1'b1;
				r.accepted  = 1'b1;
			end
			ACT_READ: begin
				if (in_frame) begin
					r.read_byte = shadow_frame[addr];
					r.accepted  = 1'b1;
				end
			end
			default: ;
		endcase
		// take reports the rectangle as it stood before the clear
		if (c.action != ACT_TAKE)
			shown = dirty_box;
		r.area_x      = shown.left;
		r.area_y      = shown.top;
		r.area_width  = shown.wide;
		r.area_height = shown.tall;
		r.baseline_ok = shadow_base;
		return r;
	endfunction

	function automatic fbdt_cmd_t make_cmd(logic [2:0] act, int x, int y, logic ink);
		fbdt_cmd_t c;
		c.action    = act;
		c.pixel_x   = 9'(x);
		c.pixel_y   = 9'(y);
		c.ink_black = ink;
		return c;
	endfunction

	// mostly writes clustered round a moving centre, reads of recent spots, takes,
	// baseline marks and forced full refreshes; the rest is off-frame, random-code and spare-code noise
	function automatic fbdt_cmd_t random_cmd();
		fbdt_cmd_t c;
		int        pick;
		int        x;
		int        y;
		c           = '0;
		c.ink_black = 1'($urandom_range(0, 1));
		pick        = $urandom_range(0, 99);
		if (pick < 50) begin
			c.action = ACT_WRITE;
			if ($urandom_range(0, 9) == 0) begin
				x = $urandom_range(0, FRAME_W - 1);
				y = $urandom_range(0, FRAME_H - 1);
			end else begin
				x = cluster_x + $urandom_range(0, 31);
				y = cluster_y + $urandom_range(0, 31);
				if (x >= FRAME_W)
					x = FRAME_W - 1;
				if (y >= FRAME_H)
					y = FRAME_H - 1;
			end
			c.pixel_x = 9'(x);
			c.pixel_y = 9'(y);
			written_spots.push_back(c);
			if (written_spots.size() > SPOT_DEPTH)
				void'(written_spots.pop_front());
		end else if (pick < 68) begin
			if (written_spots.size() > 0 && $urandom_range(0, 2) != 0)
				c = written_spots[$urandom_range(0, written_spots.size() - 1)];
			else
				c = make_cmd(ACT_READ, $urandom_range(0, FRAME_W - 1),
					$urandom_range(0, FRAME_H - 1), 1'b0);
			c.action = ACT_READ;
		end else if (pick < 78) begin
			c.action  = ACT_TAKE;
			cluster_x = $urandom_range(0, FRAME_W - 1);
			cluster_y = $urandom_range(0, FRAME_H - 1);
		end else if (pick < 85) begin
			c.action = ACT_MARK;
		end else if (pick < 89) begin
			c.action = ACT_FULL;
		end else if (pick < 94) begin
			c.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
			if ($urandom_range(0, 1)) begin
				c.pixel_x = 9'($urandom_range(FRAME_W, 511));
				c.pixel_y = 9'($urandom_range(0, 511));
			end else begin
				c.pixel_x = 9'($urandom_range(0, 511));
				c.pixel_y = 9'($urandom_range(FRAME_H, 511));
			end
		end else if (pick < 97) begin
			c.action  = 3'($urandom_range(0, 7));
			c.pixel_x = 9'($urandom_range(0, 511));
			c.pixel_y = 9'($urandom_range(0, 511));
		end else begin
			c.action  = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
			c.pixel_x = 9'($urandom_range(0, 511));
			c.pixel_y = 9'($urandom_range(0, 511));
		end
		return c;
	endfunction

	// offer one command, hold it until the transfer, predict its result, then withdraw it
	task automatic send_cmd(fbdt_cmd_t c);
		int gap;
		gap = 0;
		if (tx_idling && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 11);
		repeat (gap) @(negedge clk);
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		pending_results.push_back(apply_command(c));
		// drop valid so the same command is not taken a second time
		@(negedge clk);
		cmd_valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_power_up();
		send_cmd(make_cmd(ACT_TAKE, 0, 0, 1'b0));
		send_cmd(make_cmd(ACT_READ, 0, 0, 1'b0));
	endtask

	// corner pixels land in the first and last byte, msb and lsb
	task automatic test_frame_edges();
		send_cmd(make_cmd(ACT_WRITE, 0, 0, 1'b1));
		send_cmd(make_cmd(ACT_WRITE, FRAME_W - 1, FRAME_H - 1, 1'b1));
		send_cmd(make_cmd(ACT_READ, 0, 0, 1'b0));
		send_cmd(make_cmd(ACT_READ, FRAME_W - 1, FRAME_H - 1, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 0, 0, 1'b0));
		send_cmd(make_cmd(ACT_READ, 0, 0, 1'b0));
	endtask

	task automatic test_outside_frame();
		send_cmd(make_cmd(ACT_WRITE, FRAME_W, 0, 1'b1));
		send_cmd(make_cmd(ACT_WRITE, 0, FRAME_H, 1'b1));
		send_cmd(make_cmd(ACT_WRITE, 511, 511, 1'b1));
		send_cmd(make_cmd(ACT_READ, FRAME_W, 5, 1'b0));
		send_cmd(make_cmd(ACT_READ, 5, FRAME_H, 1'b0));
	endtask

	// with a valid baseline the rectangle starts empty and grows point by point
	task automatic test_area_merge();
		send_cmd(make_cmd(ACT_MARK, 0, 0, 1'b0));
		send_cmd(make_cmd(ACT_TAKE, 0, 0, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 200, 150, 1'b1));
		send_cmd(make_cmd(ACT_WRITE, 100, 50, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 300, 250, 1'b1));
		send_cmd(make_cmd(ACT_TAKE, 0, 0, 1'b0));
		send_cmd(make_cmd(ACT_TAKE, 0, 0, 1'b0));
	endtask

	task automatic test_force_and_spare();
		send_cmd(make_cmd(ACT_FULL, 0, 0, 1'b0));
		send_cmd(make_cmd(ACT_WRITE, 10, 10, 1'b1));
		send_cmd(make_cmd(ACT_SPARE_FIRST, 511, 511, 1'b1));
		send_cmd(make_cmd(ACT_SPARE_FIRST + 3'd1, 511, 511, 1'b1));
		send_cmd(make_cmd(ACT_SPARE_LAST, 511, 511, 1'b1));
		send_cmd(make_cmd(ACT_MARK, 0, 0, 1'b0));
	endtask

	// spare codes do nothing, so they are not counted
	task automatic test_random_traffic(int count);
		fbdt_cmd_t c;
		int        sent;
		sent = 0;
		while (sent < count) begin
			c = random_cmd();
			send_cmd(c);
			if (c.action <= ACT_READ)
				sent++;
		end
	endtask

	// results held off for a long stretch while commands keep coming
	task automatic test_result_backpressure();
		int k;
		tx_idling     = 1'b0;
		long_hold_req = 1'b1;
		for (k = 0; k < 16; k++)
			send_cmd(random_cmd());
		wait_results_drained();
	endtask

	// receiver: random stall bursts, plus the long hold when asked for
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				res_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold_req = 1'b0;
			end else if (rx_idling && $urandom_range(0, 3) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(negedge clk);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	task automatic compare_field(string label, logic [8:0] want_v, logic [8:0] got_v);
		if (got_v !== want_v) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin : result_check
		fbdt_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result transfer with none expected, expected nothing, actual %h",
					$time, res);
			end else begin
				want = pending_results.pop_front();
				compare_field("accepted", want.accepted, res.accepted);
				compare_field("read_byte", want.read_byte, res.read_byte);
				compare_field("area_x", want.area_x, res.area_x);
				compare_field("area_y", want.area_y, res.area_y);
				compare_field("area_width", want.area_width, res.area_width);
				compare_field("area_height", want.area_height, res.area_height);
				compare_field("baseline_ok", want.baseline_ok, res.baseline_ok);
			end
		end
	end

	// watchdog on cycles without a transfer on either channel
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		tx_idling   = 1'b1;
		rx_idling   = 1'b1;
		cluster_x   = 0;
		cluster_y   = 0;
		dirty_box   = '0;
		shadow_base = 1'b0;
		foreach (shadow_frame[i])
			shadow_frame[i] = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_power_up();
		test_frame_edges();
		test_outside_frame();
		test_area_merge();
		test_force_and_spare();
		wait_results_drained();

		test_random_traffic(640);
		test_result_backpressure();

		// closing stretch at full rate on both sides
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		test_random_traffic(270);
		@(negedge clk);
		cmd_valid <= 1'b0;

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
src/fbdt_pkg.sv
src/fbdt_ram.sv
src/fbdt_area.sv
src/pixel_framebuffer_dirty_tracker_top.sv
src/fbdt_checker.sv
sim/tb_pixel_framebuffer_dirty_tracker_top.sv
